>>> rtl/bmp24_pkg.sv
// Shared types and constants for the 24-bit BMP stream decoder.
// No dependencies; every RTL file of the decoder imports this package.
`default_nettype none

package bmp24_pkg;

    // Default size limits, handed to the top level as parameter defaults
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Header layout and expected field values
    localparam logic [15:0] SIG_BM       = 16'h4D42;
    localparam logic [15:0] BITS_24      = 16'd24;
    localparam logic [5:0]  HDR_LAST     = 6'd53;
    localparam logic [5:0]  SIG_POS      = 6'd0;
    localparam logic [5:0]  WIDTH_POS    = 6'd18;
    localparam logic [5:0]  HEIGHT_POS   = 6'd22;
    localparam logic [5:0]  BITCOUNT_POS = 6'd28;
    localparam logic [5:0]  COMPRESS_POS = 6'd30;
    localparam logic [5:0]  COMPRESS_END = 6'd34;

    // Result status codes
    localparam logic [2:0] ST_PIXEL      = 3'd0;
    localparam logic [2:0] ST_NOT_BMP    = 3'd1;
    localparam logic [2:0] ST_NOT_24BIT  = 3'd2;
    localparam logic [2:0] ST_COMPRESSED = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd4;

    // Parse phase of the decoder
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1,
        PH_PAD    = 2'd2,
        PH_IDLE   = 2'd3
    } phase_t;

    // Input word: one file byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_word_t;

    // Result word: one pixel or one error report
    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_pixel;
    } res_word_t;

    // Header unit to pixel sequencer: end of header and verdict
    typedef struct packed {
        logic       done;
        logic [2:0] status;
    } hdr_ctl_t;

endpackage

`default_nettype wire

>>> rtl/bmp24_hdr.sv
// Header unit: counts the 54 header bytes, captures the little-endian fields
// and checks them on the last header byte. Depends on bmp24_pkg.
`default_nettype none

module bmp24_hdr #(
    parameter int MAX_WIDTH  = bmp24_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp24_pkg::DEF_MAX_HEIGHT,
    parameter int XW         = $clog2(MAX_WIDTH + 1),
    parameter int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 file_start,
    input  wire logic                 hdr_sel,
    input  wire logic [7:0]           data_byte,
    output bmp24_pkg::hdr_ctl_t       hdr_ctl,
    output logic      [XW-1:0]        hdr_width,
    output logic      [YW-1:0]        hdr_row
);
    import bmp24_pkg::*;

    localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

    logic [5:0]  count_reg, count_next;
    logic [5:0]  pos;
    logic [5:0]  off_w, off_h, off_b, off_c;
    logic [15:0] sig_reg, sig_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] comp_reg, comp_next;
    logic        take;
    logic        w_bad, h_bad;
    logic [31:0] height_m1;

    // Restart the count on a new file
    assign pos   = file_start ? 6'd0 : count_reg;
    assign take  = step && hdr_sel;
    assign off_w = pos - WIDTH_POS;
    assign off_h = pos - HEIGHT_POS;
    assign off_b = pos - BITCOUNT_POS;
    assign off_c = pos - COMPRESS_POS;

    // Place the byte into the field it belongs to
    always_comb
    begin
        sig_next    = sig_reg;
        width_next  = width_reg;
        height_next = height_reg;
        bits_next   = bits_reg;
        comp_next   = comp_reg;
        count_next  = count_reg;
        if (take)
        begin
            priority if (pos < WIDTH_POS && pos < SIG_POS + 6'd2)
                sig_next[8*pos[0] +: 8] = data_byte;
            else if (pos >= WIDTH_POS && pos < HEIGHT_POS)
                width_next[8*off_w[1:0] +: 8] = data_byte;
            else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + 6'd4)
                height_next[8*off_h[1:0] +: 8] = data_byte;
            else if (pos >= BITCOUNT_POS && pos < COMPRESS_POS)
                bits_next[8*off_b[0] +: 8] = data_byte;
            else if (pos >= COMPRESS_POS && pos < COMPRESS_END)
                comp_next[8*off_c[1:0] +: 8] = data_byte;
            count_next = (pos == HDR_LAST) ? 6'd0 : pos + 6'd1;
        end
    end

    // Check the captured fields: signature, bit count, compression, then size
    assign w_bad = (width_reg == 32'd0) || width_reg[31] || (width_reg > MAX_W32);
    assign h_bad = (height_reg == 32'd0) || height_reg[31] || (height_reg > MAX_H32);

    always_comb
    begin
        hdr_ctl.done = take && (pos == HDR_LAST);
        priority if (sig_reg != SIG_BM)
            hdr_ctl.status = ST_NOT_BMP;
        else if (bits_reg != BITS_24)
            hdr_ctl.status = ST_NOT_24BIT;
        else if (comp_reg != 32'd0)
            hdr_ctl.status = ST_COMPRESSED;
        else if (w_bad || h_bad)
            hdr_ctl.status = ST_BAD_SIZE;
        else
            hdr_ctl.status = ST_PIXEL;
    end

    // Size fields narrowed to the counter widths; valid once checks pass
    assign height_m1 = height_reg - 32'd1;
    assign hdr_width = width_reg[XW-1:0];
    assign hdr_row   = height_m1[YW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 6'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        sig_reg    <= sig_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        bits_reg   <= bits_next;
        comp_reg   <= comp_next;
    end

endmodule

`default_nettype wire

>>> rtl/bmp24_pix.sv
// Pixel sequencer: parse phase, colour triple assembly, row padding and the
// x/y counters. Builds one result word per pixel or header error.
// Depends on bmp24_pkg.
`default_nettype none

module bmp24_pix #(
    parameter int MAX_WIDTH  = bmp24_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp24_pkg::DEF_MAX_HEIGHT,
    parameter int XW         = $clog2(MAX_WIDTH + 1),
    parameter int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 file_start,
    input  wire logic [7:0]           data_byte,
    input  wire bmp24_pkg::hdr_ctl_t  hdr_ctl,
    input  wire logic [XW-1:0]        hdr_width,
    input  wire logic [YW-1:0]        hdr_row,
    output logic                      hdr_sel,
    output logic                      res_valid,
    output bmp24_pkg::res_word_t      res_word
);
    import bmp24_pkg::*;

    phase_t          phase_reg, phase_next, phase_cur;
    logic [1:0]      comp_reg, comp_next;
    logic [XW-1:0]   col_reg, col_next, col_inc;
    logic [YW-1:0]   row_reg, row_next;
    logic [1:0]      pad_reg, pad_next;
    logic [XW-1:0]   width_reg, width_next;
    logic [7:0]      blue_reg, blue_next;
    logic [7:0]      green_reg, green_next;
    logic            row_end, last;
    logic [XW+11:0]  x_ext;
    logic [YW+11:0]  y_ext;

    // A new file always begins in the header phase
    assign phase_cur = file_start ? PH_HEADER : phase_reg;
    assign hdr_sel   = (phase_cur == PH_HEADER);

    assign col_inc = col_reg + XW'(1);
    assign row_end = (col_inc == width_reg);
    assign last    = row_end && (row_reg == '0);
    assign x_ext   = {12'd0, col_reg};
    assign y_ext   = {12'd0, row_reg};

    always_comb
    begin
        phase_next = phase_reg;
        comp_next  = comp_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pad_next   = pad_reg;
        width_next = width_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        res_valid  = 1'b0;
        res_word   = '0;
        if (step)
        begin
            phase_next = phase_cur;
            unique case (phase_cur)
                PH_HEADER:
                begin
                    if (hdr_ctl.done)
                    begin
                        if (hdr_ctl.status != ST_PIXEL)
                        begin
                            // Report the failing check, then ignore the file
                            phase_next      = PH_IDLE;
                            res_valid       = 1'b1;
                            res_word.status = hdr_ctl.status;
                        end
                        else
                        begin
                            phase_next = PH_PIXEL;
                            width_next = hdr_width;
                            row_next   = hdr_row;
                            col_next   = '0;
                            comp_next  = 2'd0;
                        end
                    end
                end
                PH_PIXEL:
                begin
                    unique case (comp_reg)
                        2'd0:
                        begin
                            blue_next = data_byte;
                            comp_next = 2'd1;
                        end
                        2'd1:
                        begin
                            green_next = data_byte;
                            comp_next  = 2'd2;
                        end
                        default:
                        begin
                            // Red byte completes the pixel
                            comp_next           = 2'd0;
                            res_valid           = 1'b1;
                            res_word.status     = ST_PIXEL;
                            res_word.pixel_x    = x_ext[11:0];
                            res_word.pixel_y    = y_ext[11:0];
                            res_word.red        = data_byte;
                            res_word.green      = green_reg;
                            res_word.blue       = blue_reg;
                            res_word.last_pixel = last;
                            col_next            = col_inc;
                            if (row_end)
                            begin
                                priority if (last)
                                    phase_next = PH_IDLE;
                                else if (width_reg[1:0] != 2'd0)
                                begin
                                    pad_next   = width_reg[1:0];
                                    phase_next = PH_PAD;
                                end
                                else
                                begin
                                    row_next   = row_reg - YW'(1);
                                    col_next   = '0;
                                    phase_next = PH_PIXEL;
                                end
                            end
                        end
                    endcase
                end
                PH_PAD:
                begin
                    // Drop padding bytes, then advance to the next row up
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1)
                    begin
                        if (row_reg == '0)
                            phase_next = PH_IDLE;
                        else
                        begin
                            row_next   = row_reg - YW'(1);
                            col_next   = '0;
                            comp_next  = 2'd0;
                            phase_next = PH_PIXEL;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            comp_reg  <= 2'd0;
            col_reg   <= '0;
            row_reg   <= '0;
            pad_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pad_reg   <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        blue_reg  <= blue_next;
        green_reg <= green_next;
    end

endmodule

`default_nettype wire

>>> rtl/bmp24_stream_decoder.sv
// Decoder for uncompressed 24-bit BMP files streamed one byte per word.
//
// Channels: byte_* carries file bytes (data_byte, file_start); res_* carries
// pixels and error reports. A word moves on a rising edge where valid is high
// and stall is low. file_start marks header byte 0 of a new file and
// restarts the parse at any point.
// An accepted byte passes the input register, the parse logic and the result
// register. Throughput: one byte per cycle while no result is held stalled,
// set by the single input and result registers around the parse logic.
// Header bytes, the blue and green bytes and row padding give no result;
// the red byte of each pixel gives one pixel word. A failed header check
// gives one error word, after which bytes are dropped until file_start.
// Reset: the decoder starts in the header phase with no words held.
// Stall: while res_stall holds a waiting result, the input register keeps
// one more byte and byte_stall rises; nothing is lost or repeated.
`default_nettype none

module bmp24_stream_decoder #(
    parameter int MAX_WIDTH  = bmp24_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp24_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire bmp24_pkg::in_word_t  byte_word,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output bmp24_pkg::res_word_t      res_word
);
    import bmp24_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic       in_valid_reg, in_valid_next;
    in_word_t   in_word_reg;
    logic       advance;
    logic       hdr_sel;
    hdr_ctl_t   hdr_ctl;
    logic [XW-1:0] hdr_width;
    logic [YW-1:0] hdr_row;
    logic       pix_valid;
    res_word_t  pix_word;
    logic       out_valid_reg, out_valid_next;
    res_word_t  out_word_reg;
    logic       out_hold;

    // Hold the result while the receiver stalls; the input stage waits on it
    assign out_hold   = out_valid_reg && res_stall;
    assign advance    = in_valid_reg && !out_hold;
    assign byte_stall = in_valid_reg && out_hold;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_valid && !byte_stall)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = out_hold ? 1'b1 : (advance && pix_valid);
    end

    bmp24_hdr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .XW         (XW),
        .YW         (YW)
    ) u_hdr (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .file_start (in_word_reg.file_start),
        .hdr_sel    (hdr_sel),
        .data_byte  (in_word_reg.data_byte),
        .hdr_ctl    (hdr_ctl),
        .hdr_width  (hdr_width),
        .hdr_row    (hdr_row)
    );

    bmp24_pix #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .XW         (XW),
        .YW         (YW)
    ) u_pix (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .file_start (in_word_reg.file_start),
        .data_byte  (in_word_reg.data_byte),
        .hdr_ctl    (hdr_ctl),
        .hdr_width  (hdr_width),
        .hdr_row    (hdr_row),
        .hdr_sel    (hdr_sel),
        .res_valid  (pix_valid),
        .res_word   (pix_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input and result words
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            in_word_reg <= byte_word;
        if (!out_hold)
            out_word_reg <= pix_word;
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

endmodule

`default_nettype wire
